### rtl/core/cgc_pkg.sv
`timescale 1ns / 1ps

package cgc_pkg;

    localparam int SAMPLE_BITS = 24;

    // register indexes of the configuration port
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATIO     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KNEE      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOFT      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAKEUP    = 3'd4;
    localparam int CFG_DATA_W = 16;

    // pipeline layout
    localparam int DIV_STEPS = 16;
    localparam int ROOT_STEPS = 16;
    localparam int ST_DIV0 = 5;
    localparam int ST_G = ST_DIV0 + DIV_STEPS;
    localparam int ST_P = ST_G + 1;
    localparam int ST_NF = ST_P + 1;
    localparam int ST_M0 = ST_NF + 1;
    localparam int ST_MAG = ST_M0 + ROOT_STEPS;
    localparam int ST_SH = ST_MAG + 1;
    localparam int ST_OUT = ST_SH + 1;

    // datapath widths
    localparam int NUM_W = 45;
    localparam int DEN_W = 32;
    localparam int M_W = 31;
    localparam int MAG_W = SAMPLE_BITS + M_W;
    localparam int MIN_SHIFT = 23;
    localparam int T_W = MAG_W - MIN_SHIFT;

    // log2(10)/5120 in Q16 log2 units per 1/256 dB, times 65536
    localparam logic signed [41:0] LOG2_SCALE = 42'sd2786635;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem = x;
        res = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) in Q30, each root taken from the one before
    function automatic logic [M_W-1:0] root_at(input int k);
        logic [63:0] r;
        r = isqrt64(64'd2 << 60);
        for (int i = 1; i <= k; i++) begin
            r = isqrt64(r << 30);
        end
        return r[M_W-1:0];
    endfunction

endpackage

### rtl/core/compressor_gain_computer.sv
`timescale 1ns / 1ps

// channel   signals                                      direction
// in        i_in_valid, o_in_ready, i_sample_in, i_level_db   request in
// out       o_out_valid, i_out_ready, o_sample_out         request out
// cfg       i_cfg_we, i_cfg_addr, i_cfg_data              register write
//
// one request per cycle while o_in_ready is high; a request reaches the output
// register through the 16 stage restoring divider and 16 root multiplies
// a skid register behind the output lets a stalled result wait while the
// pipeline keeps accepting until the skid fills; nothing is lost or repeated
// synchronous active low reset clears valid bits and loads register defaults

module compressor_gain_computer
    import cgc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [15:0]           i_level_db,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // configuration
    logic signed [15:0] r_thr;
    logic [14:0]        r_ratio;
    logic [13:0]        r_knee;
    logic               r_soft;
    logic signed [14:0] r_makeup;

    logic signed [15:0] cfg_s16;
    logic signed [14:0] cfg_s15;
    logic [14:0]        cfg_u15;
    logic [13:0]        cfg_u14;

    always_comb begin
        cfg_s16 = $signed(i_cfg_data);
        cfg_s15 = $signed(i_cfg_data[14:0]);
        cfg_u15 = i_cfg_data[14:0];
        cfg_u14 = i_cfg_data[13:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= -16'sd5120;
            r_ratio <= 15'd1024;
            r_knee <= 14'd1536;
            r_soft <= 1'b0;
            r_makeup <= 15'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: begin
                    if (cfg_s16 > 16'sd0) r_thr <= 16'sd0;
                    else if (cfg_s16 < -16'sd20480) r_thr <= -16'sd20480;
                    else r_thr <= cfg_s16;
                end
                CFG_RATIO: begin
                    if (cfg_u15 < 15'd256) r_ratio <= 15'd256;
                    else if (cfg_u15 > 15'd25600) r_ratio <= 15'd25600;
                    else r_ratio <= cfg_u15;
                end
                CFG_KNEE: begin
                    if (cfg_u14 == 14'd0) r_knee <= 14'd1;
                    else if (cfg_u14 > 14'd10240) r_knee <= 14'd10240;
                    else r_knee <= cfg_u14;
                end
                CFG_SOFT: r_soft <= i_cfg_data[0];
                CFG_MAKEUP: begin
                    if (cfg_s15 > 15'sd10240) r_makeup <= 15'sd10240;
                    else if (cfg_s15 < -15'sd10240) r_makeup <= -15'sd10240;
                    else r_makeup <= cfg_s15;
                end
                default: ;
            endcase
        end
    end

    // pipeline control
    logic               en;
    logic [ST_OUT:0]    r_v;
    logic               r_skid_v;
    logic signed [SAMPLE_BITS-1:0] r_skid;
    logic signed [SAMPLE_BITS-1:0] r_out;

    assign en = ~r_skid_v;
    assign o_in_ready = en;
    assign o_out_valid = r_skid_v | r_v[ST_OUT];
    assign o_sample_out = r_skid_v ? r_skid : r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r_v <= {r_v[ST_OUT-1:0], i_in_valid};
            end
            if (r_skid_v) begin
                if (i_out_ready) r_skid_v <= 1'b0;
            end else if (r_v[ST_OUT] && !i_out_ready) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r_v[ST_OUT] && !i_out_ready) r_skid <= r_out;
    end

    // sample travels alongside the gain path
    logic signed [SAMPLE_BITS-1:0] r_x [0:ST_MAG-1];
    logic signed [15:0] r_level;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0] <= i_sample_in;
            r_level <= i_level_db;
            for (int k = 1; k < ST_MAG; k++) r_x[k] <= r_x[k-1];
        end
    end

    // stage 1: distance to threshold and knee region
    logic signed [16:0] s1_d;
    logic signed [17:0] s1_2d;
    logic signed [17:0] s1_w;
    logic signed [17:0] s1_u;
    logic               s1_soft;
    logic               s1_zero;
    logic [15:0]        s1_a;
    logic [15:0]        r1_a;
    logic               r1_soft;
    logic               r1_zero;

    always_comb begin
        s1_d = {r_level[15], r_level} - {r_thr[15], r_thr};
        s1_2d = {s1_d, 1'b0};
        s1_w = {4'b0, r_knee};
        s1_u = s1_2d + s1_w;
        s1_soft = r_soft & (s1_2d <= s1_w);
        s1_zero = (r_soft & (s1_2d < -s1_w)) | (~s1_soft & (s1_d <= 17'sd0));
        s1_a = s1_soft ? s1_u[15:0] : s1_d[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a <= s1_a;
            r1_soft <= s1_soft;
            r1_zero <= s1_zero;
        end
    end

    // stage 2: square of the knee offset, knee times ratio
    logic [31:0] s2_sq;
    logic [28:0] s2_wr;
    logic [28:0] r2_p;
    logic [28:0] r2_wr;
    logic        r2_soft;
    logic        r2_zero;

    always_comb begin
        s2_sq = r1_a * r1_a;
        s2_wr = 29'(r_knee) * 29'(r_ratio);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_p <= r1_soft ? s2_sq[28:0] : 29'(r1_a);
            r2_wr <= s2_wr;
            r2_soft <= r1_soft;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: numerator, denominator and rounding term
    logic [14:0]       s3_rm;
    logic [NUM_W-2:0]  r3_num;
    logic [DEN_W-1:0]  r3_den;
    logic [30:0]       r3_half;
    logic              r3_zero;

    assign s3_rm = r_ratio - 15'd256;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num <= (NUM_W-1)'(r2_p) * (NUM_W-1)'(s3_rm);
            r3_den <= r2_soft ? {r2_wr, 3'b0} : DEN_W'(r_ratio);
            r3_half <= r2_soft ? {r2_wr, 2'b0} : 31'(r_ratio[14:1]);
            r3_zero <= r2_zero;
        end
    end

    // stage 4 and divider: quotient bits msb first
    logic [NUM_W-1:0] r_dn [0:DIV_STEPS];
    logic [DEN_W-1:0] r_dd [0:DIV_STEPS];
    logic [15:0]      r_dq [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dn[0] <= r3_zero ? '0 : NUM_W'(r3_num) + NUM_W'(r3_half);
            r_dd[0] <= r3_den;
            r_dq[0] <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [NUM_W+1:0] sub;
        logic             take;

        always_comb begin
            sub = (NUM_W+2)'(r_dd[k]) << SH;
            take = {2'b0, r_dn[k]} >= sub;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dn[k+1] <= take ? r_dn[k] - sub[NUM_W-1:0] : r_dn[k];
                r_dd[k+1] <= r_dd[k];
                r_dq[k+1] <= r_dq[k] | (take ? 16'(1) << SH : 16'd0);
            end
        end
    end

    // gain in 1/256 dB, then to log2 units in Q16
    logic signed [17:0] r_g;
    logic signed [41:0] r_p;
    logic signed [6:0]  r_mn [0:ROOT_STEPS];
    logic [15:0]        r_mf [0:ROOT_STEPS];
    logic [M_W-1:0]     r_mm [0:ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g <= {{3{r_makeup[14]}}, r_makeup} - {2'b0, r_dq[DIV_STEPS]};
            r_p <= 42'(r_g) * LOG2_SCALE + 42'sd32768;
            r_mn[0] <= r_p[38:32];
            r_mf[0] <= r_p[31:16];
            r_mm[0] <= M_W'(1) << 30;
        end
    end

    // fractional power of two, one root multiply per stage
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        localparam logic [M_W-1:0] ROOT = root_at(k);
        logic [2*M_W-1:0] prod;

        assign prod = (2*M_W)'(r_mm[k]) * (2*M_W)'(ROOT) + (2*M_W)'(1 << 29);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mm[k+1] <= r_mf[k][15-k] ? prod[30 +: M_W] : r_mm[k];
                r_mn[k+1] <= r_mn[k];
                r_mf[k+1] <= r_mf[k];
            end
        end
    end

    // apply gain: magnitude product, rounding shift, saturation
    logic [SAMPLE_BITS-1:0]        s_abs;
    logic signed [SAMPLE_BITS-1:0] s_xl;
    logic signed [7:0]             s_sh;
    logic [MAG_W-1:0]              r_mag;
    logic [6:0]                    r_shamt;
    logic                          r_neg_a;
    logic                          r_neg_b;
    logic [MAG_W-1:0]              s_t;
    logic [T_W:0]                  s_tp;
    logic [T_W-1:0]                r_res;
    logic [T_W-1:0]                s_maxv;

    always_comb begin
        s_xl = r_x[ST_MAG-1];
        s_abs = s_xl[SAMPLE_BITS-1] ? SAMPLE_BITS'(-s_xl) : SAMPLE_BITS'(s_xl);
        s_sh = 8'sd29 - {r_mn[ROOT_STEPS][6], r_mn[ROOT_STEPS]};
        s_t = r_mag >> r_shamt;
        s_tp = {1'b0, s_t[T_W-1:0]} + (T_W+1)'(1);
        s_maxv = T_W'((1 << (SAMPLE_BITS - 1)) - 1);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag <= MAG_W'(s_abs) * MAG_W'(r_mm[ROOT_STEPS]);
            r_shamt <= s_sh[6:0];
            r_neg_a <= s_xl[SAMPLE_BITS-1];
            r_res <= s_tp[T_W:1];
            r_neg_b <= r_neg_a;
            if (r_neg_b) begin
                if (r_res > s_maxv + T_W'(1))
                    r_out <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                else
                    r_out <= -$signed(r_res[SAMPLE_BITS-1:0]);
            end else begin
                if (r_res > s_maxv)
                    r_out <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                else
                    r_out <= $signed(r_res[SAMPLE_BITS-1:0]);
            end
        end
    end

endmodule

### bench/cgc_checker.sv
`timescale 1ns / 1ps

module cgc_checker
    import cgc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [15:0]            i_level_db,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_out,
    input  logic                          i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results
);

    logic signed [63:0] thr_db;
    logic signed [63:0] ratio;
    logic signed [63:0] knee;
    logic               knee_soft;
    logic signed [63:0] makeup;
    logic [63:0]        roots [16];
    logic signed [SAMPLE_BITS-1:0] expected_samples [$];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= x) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // gain reduction of the static curve, 1/256 dB, never positive
    function automatic logic signed [63:0] curve_reduction(input logic signed [63:0] lvl);
        logic signed [63:0] d;
        logic [63:0] num;
        logic [63:0] den;
        d = lvl - thr_db;
        if (knee_soft && 2 * d <= knee) begin
            if (2 * d < -knee) return 0;
            num = 2 * d + knee;
            num = num * num * (ratio - 256);
            den = 8 * knee * ratio;
            return -$signed((num + den / 2) / den);
        end
        if (d <= 0) return 0;
        num = d * (ratio - 256);
        return -$signed((num + ratio / 2) / ratio);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] gained_sample(
        input logic signed [SAMPLE_BITS-1:0] x, input logic signed [15:0] lvl);
        logic signed [63:0] g;
        logic signed [63:0] e;
        logic signed [63:0] n;
        logic signed [63:0] sh;
        logic signed [63:0] maxv;
        logic [63:0] m;
        logic [63:0] mag;
        logic [15:0] f;
        g = curve_reduction(lvl) + makeup;
        e = (g * 2786635 + 32768) >>> 16;
        n = e >>> 16;
        f = e[15:0];
        m = 64'd1 << 30;
        for (int k = 0; k < 16; k++) begin
            if (f[15-k]) m = (m * roots[k] + (64'd1 << 29)) >> 30;
        end
        mag = (x < 0 ? -64'(x) : 64'(x)) * m;
        sh = 30 - n;
        if (sh >= 64) mag = 0;
        else mag = (mag + (64'd1 << (sh - 1))) >> sh;
        maxv = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        if (x < 0) return (mag > maxv + 1) ? -(maxv + 1) : -$signed(mag);
        return (mag > maxv) ? maxv : $signed(mag);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        logic [63:0] r;
        o_fail_count = 0;
        o_results = 0;
        r = 64'd2 << 60;
        roots[0] = sqrt_floor(r);
        for (int k = 1; k < 16; k++) begin
            roots[k] = sqrt_floor(roots[k-1] << 30);
        end
    end

    assign o_pending = expected_samples.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_db <= -5120;
            ratio <= 1024;
            knee <= 1536;
            knee_soft <= 1'b0;
            makeup <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_THRESHOLD: thr_db <= clamp64($signed(i_cfg_data), -20480, 0);
                    CFG_RATIO:     ratio <= clamp64(i_cfg_data[14:0], 256, 25600);
                    CFG_KNEE:      knee <= clamp64(i_cfg_data[13:0], 1, 10240);
                    CFG_SOFT:      knee_soft <= i_cfg_data[0];
                    CFG_MAKEUP:    makeup <= clamp64($signed(i_cfg_data[14:0]), -10240,
                                                     10240);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(gained_sample(i_sample_in, i_level_db));
            end
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_samples.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    if (i_sample_out !== expected_samples[0]) begin
                        report_mismatch($sformatf("sample_out %0d, expected %0d",
                                                  i_sample_out, expected_samples[0]));
                    end
                    void'(expected_samples.pop_front());
                end
            end
        end
    end

endmodule

### bench/tb_compressor_gain_computer.sv
`timescale 1ns / 1ps

module tb_compressor_gain_computer
    import cgc_pkg::*;
();

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [15:0]            level_db;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          cfg_we;
    logic [CFG_ADDR_W-1:0]         cfg_addr;
    logic [CFG_DATA_W-1:0]         cfg_data;
    int fail_count;
    int pending;
    int results;
    int sender_idle_pct;
    int receiver_stall_pct;
    int idle_cycles;
    int requests;

    compressor_gain_computer dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_sample_in(sample_in), .i_level_db(level_db),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_sample_out(sample_out),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data)
    );

    cgc_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_sample_in(sample_in), .i_level_db(level_db),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_sample_out(sample_out),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random, changed on the falling edge
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: cycles with no request moving either way
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // valid stays up into the next request; idling or draining drops it
    task automatic send_request(input logic signed [SAMPLE_BITS-1:0] x,
                                input logic signed [15:0] lvl);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= x;
        level_db <= lvl;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_config();
        write_reg(CFG_THRESHOLD, $urandom_range(3) == 0 ? 16'($urandom)
                                 : 16'(-$signed($urandom_range(20480))));
        write_reg(CFG_RATIO, $urandom_range(4) == 0 ? 16'($urandom)
                             : 16'($urandom_range(25600, 256)));
        write_reg(CFG_KNEE, $urandom_range(4) == 0 ? 16'($urandom)
                            : 16'($urandom_range(10240)));
        write_reg(CFG_SOFT, 16'($urandom_range(1)));
        write_reg(CFG_MAKEUP, $urandom_range(4) == 0 ? 16'($urandom)
                              : 16'($signed($urandom_range(20480)) - 10240));
        // indexes past the list are ignored
        write_reg(CFG_ADDR_W'(5 + $urandom_range(2)), 16'($urandom));
    endtask

    task automatic random_item();
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [15:0] lvl;
        x = SAMPLE_BITS'($urandom);
        if ($urandom_range(9) == 0) x = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        // most levels spread over the threshold range, where the curve bends
        case ($urandom_range(3))
            0: lvl = 16'($urandom);
            default: lvl = 16'(-$signed($urandom_range(20480)) +
                               $signed($urandom_range(3000)) - 1500);
        endcase
        send_request(x, lvl);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        level_db = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        idle_cycles = 0;
        requests = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, field extremes
        send_request(24'sh7fffff, 16'sh7fff);
        send_request(24'sh800000, 16'sh8000);
        send_request(24'sh000000, 16'sh0000);
        send_request(24'sh000001, -16'sd5120);
        send_request(24'shffffff, -16'sd5121);
        wait_drained();
        // out of range writes clamp, zero knee reads as one, soft knee on
        write_reg(CFG_THRESHOLD, 16'h7fff);
        write_reg(CFG_RATIO, 16'h7fff);
        write_reg(CFG_KNEE, 16'h0000);
        write_reg(CFG_SOFT, 16'h0001);
        write_reg(CFG_MAKEUP, 16'h3fff);
        send_request(24'sh7fffff, 16'sh0000);
        send_request(24'sh400000, -16'sd1);
        send_request(24'sh800000, 16'sh7fff);
        wait_drained();
        // lowest threshold, ratio clamps to 1:1, widest knee, makeup clamps to deepest cut
        write_reg(CFG_THRESHOLD, 16'h8000);
        write_reg(CFG_RATIO, 16'h0000);
        write_reg(CFG_KNEE, 16'h3fff);
        write_reg(CFG_MAKEUP, 16'h4000);
        send_request(24'sh7fffff, 16'sh7fff);
        send_request(24'sh800000, -16'sd20480);
        send_request(24'sh123456, -16'sd15360);
        send_request(24'shedcba9, -16'sd25600);
        wait_drained();
        write_reg(CFG_RATIO, 16'd25600);
        write_reg(CFG_MAKEUP, 16'h2800);
        write_reg(CFG_THRESHOLD, 16'h0000);
        send_request(24'sh7fffff, 16'sh7fff);
        send_request(24'sh800000, 16'sh1000);
        send_request(24'sh000fff, -16'sd100);
        wait_drained();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            endcase
            random_config();
            repeat (150) random_item();
            wait_drained();
        end

        $display("%0d requests over reset, clamped and random settings, hard and soft knee",
                 requests);
        $display("%0d results checked under four idle and stall mixes", results);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/cgc_pkg.sv
rtl/core/compressor_gain_computer.sv
bench/cgc_checker.sv
bench/tb_compressor_gain_computer.sv
